// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sgmf_pkg.sv
// Package for the sorted-group median filter: widths, slot counts, types.
// No dependencies.
`default_nettype none

package sgmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STORE_SLOTS = 6;
  localparam int CARRY_SLOTS = 2;
  localparam int CNT_BITS    = $clog2(STORE_SLOTS + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_BITS-1:0]    count_t;

  localparam count_t CARRY_CNT = count_t'(CARRY_SLOTS);
  localparam count_t LAST_CNT  = count_t'(STORE_SLOTS - 1);

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;    // capture the request's sample
    logic insert;  // insert the captured sample into the sorted store
    logic finish;  // average the middle pair, carry it over, restart group
    logic emit;    // load the output register
  } sgmf_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;    // the current insert completes a group
  } sgmf_status_t;

endpackage

`default_nettype wire

// File: rtl/sorted_group_median_filter_core.sv
// Sorted-group median filter, one channel: takes one sample per request and
// returns the held filtered value and a fresh flag. Each request goes through
// the controller sequence (accept, insert, emit), with an extra finish step
// when it completes a group of four samples (to average the middle pair and
// carry it into the next group); the next request is taken in the cycle after
// emit. A result waits in the output register while the next request is
// accepted, and only a stalled output blocks the emit step. The sorted store
// is six registers updated by a parallel compare-and-shift; the average of the
// two middle slots uses a sum one bit wider than a sample, so it never wraps.
// Results carry zero in filtered until the first group ends.
// Depends on sgmf_pkg, sgmf_ctrl, sgmf_datapath.
`default_nettype none

module sorted_group_median_filter_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sgmf_pkg::sample_t sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sgmf_pkg::sample_t      filtered,
  output logic                   fresh
);
  import sgmf_pkg::*;

  sgmf_cmd_t    cmd;
  sgmf_status_t status;

  // Sequence one request at a time.
  sgmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Hold the sorted store, the held average and the result register.
  sgmf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .sample   (sample),
    .filtered (filtered),
    .fresh    (fresh)
  );

endmodule

`default_nettype wire

// File: rtl/sgmf_datapath.sv
// Datapath: sorted store, fill count, held average and output register.
// Depends on sgmf_pkg; driven by sgmf_ctrl commands.
`default_nettype none

module sgmf_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sgmf_pkg::sgmf_cmd_t   cmd,
  output sgmf_pkg::sgmf_status_t     status,
  input  wire sgmf_pkg::sample_t     sample,
  output sgmf_pkg::sample_t          filtered,
  output logic                       fresh
);
  import sgmf_pkg::*;

  sample_t slots [STORE_SLOTS];
  sample_t slots_next [STORE_SLOTS];
  sample_t value;
  sample_t average;
  count_t  count;
  count_t  eff_count;
  logic    pending;
  logic    [STORE_SLOTS-1:0] lt;
  logic    [SAMPLE_BITS:0]   sum;

  // Out-of-range count acts as the start of a group.
  assign eff_count = (count < CARRY_CNT || count > LAST_CNT) ? CARRY_CNT : count;
  assign status.full = (eff_count == LAST_CNT);
  assign sum = {1'b0, slots[2]} + {1'b0, slots[3]};

  // Parallel compare-and-shift insertion; equal values go after stored ones.
  always_comb begin
    for (int i = 0; i < STORE_SLOTS; i++) begin
      lt[i] = (count_t'(i) < eff_count) && (value < slots[i]);
    end
    for (int i = 0; i < STORE_SLOTS; i++) begin
      if (count_t'(i) < eff_count && !lt[i]) begin
        slots_next[i] = slots[i];
      end else if (i == 0) begin
        slots_next[i] = value;
      end else if (lt[i-1]) begin
        slots_next[i] = slots[i-1];
      end else if (count_t'(i) <= eff_count) begin
        slots_next[i] = value;
      end else begin
        slots_next[i] = slots[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_SLOTS; i++) begin
        slots[i] <= '0;
      end
      count   <= CARRY_CNT;
      average <= '0;
      pending <= 1'b0;
    end else begin
      if (cmd.insert) begin
        for (int i = 0; i < STORE_SLOTS; i++) begin
          slots[i] <= slots_next[i];
        end
        count   <= eff_count + count_t'(1);
        pending <= 1'b0;
      end else if (cmd.finish) begin
        slots[0] <= slots[2];
        slots[1] <= slots[3];
        count    <= CARRY_CNT;
        average  <= sum[SAMPLE_BITS:1];
        pending  <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= sample;
    end
    if (cmd.emit) begin
      filtered <= average;
      fresh    <= pending;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sgmf_ctrl.sv
// Controller: sequences accept, insert, finish and emit for one request.
// Depends on sgmf_pkg; drives sgmf_datapath commands.
`default_nettype none

module sgmf_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output sgmf_pkg::sgmf_cmd_t         cmd,
  input  wire sgmf_pkg::sgmf_status_t status
);
  import sgmf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.insert = (state == S_INSERT);
    cmd.finish = (state == S_FINISH);
    cmd.emit   = (state == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_INSERT;
        S_INSERT: state <= status.full ? S_FINISH : S_EMIT;
        S_FINISH: state <= S_EMIT;
        S_EMIT:   if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/sgmf_checker.sv
// Port-level checker for sorted_group_median_filter_core, bound to the top.
// Depends on sgmf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sgmf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sgmf_pkg::sample_t filtered,
  input wire logic              fresh
);
  import sgmf_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_cnt;
  logic [1:0] group_pos;
  sample_t    last_filt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt  <= '0;
      group_pos <= '0;
      last_filt <= '0;
    end else begin
      open_cnt <= open_cnt + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        group_pos <= group_pos + 2'd1;
        last_filt <= filtered;
      end
    end
  end

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
               out_valid && $stable(filtered) && $stable(fresh), "stalled result changed")
  `ASSERT_SAME(a_no_invent, out_valid, open_cnt != 2'd0, "result without a request")
  `ASSERT_SAME(a_fresh_every_fourth, out_valid, fresh == (group_pos == 2'd3),
               "fresh flag off group")
  `ASSERT_SAME(a_held_value, out_valid && !fresh, filtered == last_filt,
               "held value changed")
  `ASSERT_NEXT(a_one_at_a_time, in_acc, in_stall, "request taken while busy")

endmodule

bind sorted_group_median_filter_core sgmf_checker u_sgmf_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_group_median_filter_core: a directed table
// followed by random samples, each result checked against a typed value or a behavioral model.
// Depends on sgmf_pkg and the RTL of the filter core.

module testbench;
  import sgmf_pkg::*;

  // One expected result: the held filter value and its fresh flag.
  typedef struct packed {
    sample_t filtered;
    logic    fresh;
  } filter_result_t;

  // One row of the directed stimulus. Rows with typed set carry a result that
  // can be read straight off the filter's definition; the rest use the model.
  typedef struct packed {
    sample_t sample;
    logic    typed;
    sample_t exp_filtered;
    logic    exp_fresh;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int IDLE_PERCENT  = 18;
  // Window of accepted requests in which neither side idles.
  localparam int QUIET_FIRST   = 600;
  localparam int QUIET_LAST    = 800;
  // Long receiver hold-off, started once this many requests have gone in.
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_CYCLES  = 8;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  sample_t sample;
  logic    out_valid;
  logic    out_stall;
  sample_t filtered;
  logic    fresh;

  // Model state: the sorted slots, the occupied count and the held average.
  sample_t median_store [STORE_SLOTS];
  int      group_fill;
  sample_t held_filtered;

  filter_result_t pending_results [$];
  int             accepted_total;
  int             error_count;

  // Directed rows. After reset the carried pair is zero, so the first three
  // requests return zero; four all-ones samples then average to all ones,
  // which only holds if the middle-pair sum does not wrap. Four zeros next
  // leave the all-ones pair above the middle, so the average drops to zero.
  // Equal samples, alternating bit patterns and near-extremes follow.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
    '{16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b1, 16'h0000, 1'b1},
    '{16'h8000, 1'b0, 16'h0000, 1'b0},
    '{16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{16'h5555, 1'b0, 16'h0000, 1'b0},
    '{16'hAAAA, 1'b0, 16'h0000, 1'b0},
    '{16'h1234, 1'b0, 16'h0000, 1'b0},
    '{16'h1234, 1'b0, 16'h0000, 1'b0},
    '{16'h1234, 1'b0, 16'h0000, 1'b0},
    '{16'h1234, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFE, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFE, 1'b0, 16'h0000, 1'b0}
  };

  sorted_group_median_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered),
    .fresh     (fresh)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Insert one sample into the model's sorted store and return the result
  // the block owes for it. An equal value goes after the one already stored.
  function automatic filter_result_t filter_sample(input sample_t value);
    int                   pos;
    logic [SAMPLE_BITS:0] pair_sum;
    filter_result_t       res;
    if (group_fill < CARRY_SLOTS || group_fill >= STORE_SLOTS) begin
      group_fill = CARRY_SLOTS;
    end
    pos = group_fill;
    while (pos > 0 && value < median_store[pos-1]) begin
      median_store[pos] = median_store[pos-1];
      pos--;
    end
    median_store[pos] = value;
    group_fill++;
    res.fresh = 1'b0;
    if (group_fill == STORE_SLOTS) begin
      // Average the middle pair with a sum one bit wider, then carry it into slots 0 and 1.
      pair_sum        = {1'b0, median_store[2]} + {1'b0, median_store[3]};
      held_filtered   = pair_sum[SAMPLE_BITS:1];
      median_store[0] = median_store[2];
      median_store[1] = median_store[3];
      group_fill      = CARRY_SLOTS;
      res.fresh       = 1'b1;
    end
    res.filtered = held_filtered;
    return res;
  endfunction

  function automatic bit in_quiet_window();
    return accepted_total >= QUIET_FIRST && accepted_total < QUIET_LAST;
  endfunction

  // Offer one request, idling first at random, and hold it until accepted.
  // On acceptance, advance the model and queue the result it predicts; a
  // typed row queues its typed result instead.
  task automatic offer_request(input sample_t value, input logic typed,
                               input filter_result_t typed_result);
    int             gap;
    filter_result_t predicted;
    if (!in_quiet_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted_total++;
    predicted = filter_sample(value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Sender: reset, directed rows, random samples, then drain.
  initial begin : sender
    filter_result_t typed_result;
    sample_t        value;
    sample_t        last_value;
    int             pick;
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample         = '0;
    accepted_total = 0;
    error_count    = 0;
    held_filtered  = '0;
    group_fill     = CARRY_SLOTS;
    last_value     = '0;
    for (int k = 0; k < STORE_SLOTS; k++) median_store[k] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      typed_result.filtered = directed_rows[r].exp_filtered;
      typed_result.fresh    = directed_rows[r].exp_fresh;
      offer_request(directed_rows[r].sample, directed_rows[r].typed, typed_result);
    end

    // Random part: mostly full-range values, with clusters of small and
    // large values and repeats so that equal keys are common in a group.
    typed_result = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      value = sample_t'($urandom);
      else if (pick < 60) value = sample_t'($urandom_range(0, 7));
      else if (pick < 72) value = sample_t'($urandom_range(16'hFFF8, 16'hFFFF));
      else if (pick < 84) value = last_value;
      else begin
        case ($urandom_range(0, 3))
          0:       value = 16'h0000;
          1:       value = 16'hFFFF;
          2:       value = 16'h8000;
          default: value = 16'h7FFF;
        endcase
      end
      last_value = value;
      offer_request(value, 1'b0, typed_result);
    end
    in_valid <= 1'b0;

    // Wait for every expected result, then keep watching for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Receiver: stall at random, hold off once for a long stretch so the
  // block backs up into its input, and never stall in the quiet window.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && accepted_total >= HOLD_AT) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else if (in_quiet_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: filtered=%h fresh=%b", filtered, fresh);
        end
      end else begin
        want = pending_results.pop_front();
        if (filtered !== want.filtered || fresh !== want.fresh) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected filtered=%h fresh=%b, got filtered=%h fresh=%b",
                     want.filtered, want.fresh, filtered, fresh);
          end
        end
      end
    end
  end

  // Drop the run if it hangs well past the slowest correct finish.
  initial begin : watchdog
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
